>>> rtl/homogeneous_point_transform_defines.svh
// ----------------------------------------------------------------------------
// homogeneous point transform assertion macros
// concurrent checks, compiled away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
// check with the usual reset qualifier
`define HPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hpt assertion failed");
// check that also holds through reset
`define HPT_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("hpt assertion failed");
`else
`define HPT_ASSERT(lbl, clk, rst_n, prop)
`define HPT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// shared types and constants of the homogeneous point transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    // default value width of the arithmetic
    localparam int VALUE_WIDTH_DEF = 32;
    // fixed field widths and matrix entry count
    localparam int FIELD_W = 32;
    localparam int IDX_W   = 4;
    localparam int EPS_W   = 16;
    localparam int MAT_N   = 16;
    // one in q16.16 and epsilon after reset
    localparam int ONE_Q16   = 65536;
    localparam int EPS_RESET = 1;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_DIR   = 2'd2,
        CMD_TDIR  = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/hpt_if.sv
// ----------------------------------------------------------------------------
// hpt channel interfaces
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hpt_in_if;
    logic                                valid;
    logic                                ready;
    hpt_pkg::t_cmd                       command;
    logic [hpt_pkg::IDX_W-1:0]           entry_index;
    logic signed [hpt_pkg::FIELD_W-1:0]  entry_value;
    logic signed [hpt_pkg::FIELD_W-1:0]  x_coord;
    logic signed [hpt_pkg::FIELD_W-1:0]  y_coord;
    logic signed [hpt_pkg::FIELD_W-1:0]  z_coord;

    modport source (output valid, command, entry_index, entry_value, x_coord, y_coord,
                    z_coord, input ready);
    modport sink (input valid, command, entry_index, entry_value, x_coord, y_coord,
                  z_coord, output ready);
endinterface

interface hpt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpt_pkg::FIELD_W-1:0]  out_x;
    logic signed [hpt_pkg::FIELD_W-1:0]  out_y;
    logic signed [hpt_pkg::FIELD_W-1:0]  out_z;
    logic                                degenerate;
    logic                                saturated;

    modport source (output valid, out_x, out_y, out_z, degenerate, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, degenerate, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// pipelined restoring divider, one quotient bit per stage, W+1 stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_div #(
    parameter int W  = hpt_pkg::VALUE_WIDTH_DEF,
    parameter int NW = 2 * hpt_pkg::VALUE_WIDTH_DEF - 14,
    parameter int RW = 3 * hpt_pkg::VALUE_WIDTH_DEF - 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [NW-1:0] i_mw,
    output logic      [W:0]    o_q
);

    localparam int QW = W + 1;

    logic [RW-1:0] r_rem [QW];
    logic [NW-1:0] r_mw  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = W - s;
        logic [RW-1:0] w_rem_in;
        logic [RW-1:0] w_div;
        logic [NW-1:0] w_mw_in;
        logic [QW-1:0] w_q_in;
        logic          w_ge;

        // stage inputs
        if (s == 0) begin : g_first
            assign w_rem_in = i_rem;
            assign w_mw_in  = i_mw;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_mw_in  = r_mw[s-1];
            assign w_q_in   = r_q[s-1];
        end

        // trial subtract of the shifted divisor
        assign w_div = RW'(w_mw_in) << B;
        assign w_ge  = w_rem_in >= w_div;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_rem_in - w_div) : w_rem_in;
                r_mw[s]  <= w_mw_in;
                r_q[s]   <= w_q_in | (QW'(w_ge) << B);
            end
        end
    end

    assign o_q = r_q[W];

endmodule

`default_nettype wire

>>> rtl/homogeneous_point_transform.sv
// a command beat passes stages 1, 2 and 3, the divider stages and the output register
// throughput: one command beat per cycle unless the result beat stalls, loads included
// a load takes effect for every transform accepted after it and produces no result beat
// reset (synchronous, active low) restores the identity matrix and epsilon of 1
// a stalled result beat stalls the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 row-vector matrix transform of q16.16 points and directions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "homogeneous_point_transform_defines.svh"

module homogeneous_point_transform #(
    parameter int VALUE_WIDTH = hpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    hpt_in_if.sink                         i_in,
    hpt_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [hpt_pkg::EPS_W-1:0] i_cfg_wdata
);

    localparam int W     = VALUE_WIDTH;
    localparam int SW    = (W > 18) ? W : 18;
    localparam int PW    = SW + W;
    localparam int TW    = PW - 16;
    localparam int NW    = TW + 2;
    localparam int RW    = NW + W + 1;
    localparam int QW    = W + 1;
    localparam int DEPTH = W + 1;
    localparam int FW    = hpt_pkg::FIELD_W;
    localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
    localparam logic signed [NW-1:0] NMAX = NW'(VMAX64);
    localparam logic signed [NW-1:0] NMIN = NW'(VMIN64);
    localparam logic signed [W-1:0]  WMAX = W'(VMAX64);
    localparam logic signed [W-1:0]  WMIN = W'(VMIN64);

    typedef struct packed {
        logic                vld;
        logic                pnt;
        logic                dgn;
        logic [2:0]          neg;
        logic [2:0]          ovf;
        logic                clip;
        logic [2:0][W-1:0]   dres;
    } t_side_s;

    // clamp a 32-bit field to the value range
    function automatic logic signed [W-1:0] f_clamp_in(input logic signed [FW-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > VMAX64) begin
            x = VMAX64;
        end else if (x < VMIN64) begin
            x = VMIN64;
        end
        return W'(x);
    endfunction

    logic w_en;
    logic w_fire;

    logic [hpt_pkg::EPS_W-1:0] r_eps;
    logic signed [SW-1:0]      r_mat [hpt_pkg::MAT_N];

    logic signed [W-1:0]  w_v    [3];
    logic signed [SW-1:0] w_coef [3][4];
    logic signed [PW-1:0] w_prod [3][4];

    logic                 r1_v;
    hpt_pkg::t_cmd        r1_cmd;
    logic signed [PW-1:0] r1_p [3][4];
    logic signed [SW-1:0] r1_t [4];

    logic                 r2_v;
    hpt_pkg::t_cmd        r2_cmd;
    logic signed [NW-1:0] r2_n [4];
    logic signed [NW-1:0] n2_n [4];

    logic [RW-1:0] r3_rem [3];
    logic [RW-1:0] n3_rem [3];
    logic [NW-1:0] r3_mw;
    logic [NW-1:0] n3_mw;
    t_side_s       r3_side;
    t_side_s       n3_side;

    t_side_s       r_side [DEPTH];
    logic [QW-1:0] w_q [3];

    logic                r_o_v;
    logic signed [FW-1:0] r_o_x, r_o_y, r_o_z;
    logic                r_o_dgn, r_o_sat;
    logic signed [W-1:0] n_res [3];
    logic                n_clip;

    // global advance: move when the output register is free or being taken
    assign w_en       = !r_o_v || o_out.ready;
    assign i_in.ready = w_en;
    assign w_fire     = i_in.valid && w_en;

    // epsilon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= hpt_pkg::EPS_W'(hpt_pkg::EPS_RESET);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // matrix store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::MAT_N; i++) begin
                r_mat[i] <= ((i % 5) == 0) ? SW'(hpt_pkg::ONE_Q16) : '0;
            end
        end else if (w_fire && i_in.command == hpt_pkg::CMD_LOAD) begin
            r_mat[i_in.entry_index] <= SW'(f_clamp_in(i_in.entry_value));
        end
    end

    // stage 1 operands: clamped vector and coefficient selection
    always_comb begin
        w_v[0] = f_clamp_in(i_in.x_coord);
        w_v[1] = f_clamp_in(i_in.y_coord);
        w_v[2] = f_clamp_in(i_in.z_coord);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (j < 3 && i_in.command == hpt_pkg::CMD_TDIR) begin
                    w_coef[i][j] = r_mat[j*4 + i];
                end else begin
                    w_coef[i][j] = r_mat[i*4 + j];
                end
                w_prod[i][j] = w_v[i] * w_coef[i][j];
            end
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_fire && (i_in.command != hpt_pkg::CMD_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= i_in.command;
            r1_p   <= w_prod;
            for (int j = 0; j < 4; j++) begin
                r1_t[j] <= r_mat[12 + j];
            end
        end
    end

    // stage 2: floor by 2^16 and sum, translation for points only
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n2_n[j] = (r1_cmd == hpt_pkg::CMD_POINT) ? NW'(r1_t[j]) : '0;
            for (int i = 0; i < 3; i++) begin
                n2_n[j] = n2_n[j] + NW'(TW'(r1_p[i][j] >>> 16));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cmd <= r1_cmd;
            r2_n   <= n2_n;
        end
    end

    // stage 3: magnitudes, degenerate test, overflow test, direction clamp
    always_comb begin
        logic [NW-1:0] mn;
        n3_mw        = r2_n[3][NW-1] ? NW'(-r2_n[3]) : NW'(r2_n[3]);
        n3_side      = '0;
        n3_side.vld  = r2_v;
        n3_side.pnt  = (r2_cmd == hpt_pkg::CMD_POINT);
        n3_side.dgn  = (r2_n[3] == '0) || (n3_mw < NW'(r_eps));
        for (int j = 0; j < 3; j++) begin
            mn              = r2_n[j][NW-1] ? NW'(-r2_n[j]) : NW'(r2_n[j]);
            n3_rem[j]       = RW'(mn) << 16;
            n3_side.neg[j]  = r2_n[j][NW-1] ^ r2_n[3][NW-1];
            n3_side.ovf[j]  = n3_rem[j] >= (RW'(n3_mw) << QW);
            if (r2_n[j] > NMAX) begin
                n3_side.dres[j] = WMAX;
                n3_side.clip    = 1'b1;
            end else if (r2_n[j] < NMIN) begin
                n3_side.dres[j] = WMIN;
                n3_side.clip    = 1'b1;
            end else begin
                n3_side.dres[j] = W'(r2_n[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.vld <= 1'b0;
        end else if (w_en) begin
            r3_side <= n3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rem <= n3_rem;
            r3_mw  <= n3_mw;
        end
    end

    // quotient lanes
    for (genvar j = 0; j < 3; j++) begin : g_div
        hpt_div #(
            .W  (W),
            .NW (NW),
            .RW (RW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (r3_rem[j]),
            .i_mw  (r3_mw),
            .o_q   (w_q[j])
        );
    end

    // sideband travelling beside the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0] <= r3_side;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // final sign and saturation
    always_comb begin
        logic sat;
        n_clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            sat = 1'b0;
            if (!r_side[W].pnt) begin
                n_res[j] = r_side[W].dres[j];
            end else if (r_side[W].dgn) begin
                n_res[j] = '0;
            end else if (!r_side[W].neg[j]) begin
                sat      = r_side[W].ovf[j] || w_q[j][W] || w_q[j][W-1];
                n_res[j] = sat ? WMAX : W'(w_q[j][W-1:0]);
            end else begin
                sat      = r_side[W].ovf[j] || w_q[j][W] ||
                           (w_q[j][W-1] && (|w_q[j][W-2:0]));
                n_res[j] = sat ? WMIN : W'(-w_q[j][W-1:0]);
            end
            n_clip = n_clip || sat;
        end
        if (!r_side[W].pnt) begin
            n_clip = r_side[W].clip;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_side[W].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] ex, ey, ez;
        ex = 64'(n_res[0]);
        ey = 64'(n_res[1]);
        ez = 64'(n_res[2]);
        if (w_en) begin
            r_o_x   <= ex[FW-1:0];
            r_o_y   <= ey[FW-1:0];
            r_o_z   <= ez[FW-1:0];
            r_o_dgn <= r_side[W].pnt && r_side[W].dgn;
            r_o_sat <= n_clip;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.out_x      = r_o_x;
    assign o_out.out_y      = r_o_y;
    assign o_out.out_z      = r_o_z;
    assign o_out.degenerate = r_o_dgn;
    assign o_out.saturated  = r_o_sat;

    // checks
    `HPT_ASSERT(a_load_no_beat, i_clk, i_rst_n,
                (w_fire && i_in.command == hpt_pkg::CMD_LOAD) |=> !r1_v)
    `HPT_ASSERT(a_degen_clear, i_clk, i_rst_n,
                (r_o_v && r_o_dgn) |->
                (r_o_x == '0 && r_o_y == '0 && r_o_z == '0 && !r_o_sat))
    `HPT_ASSERT(a_stall_hold, i_clk, i_rst_n,
                (!w_en) |=> (r_o_v && $stable(r1_v) && $stable(r2_v) && $stable(r_o_x)))

endmodule

`default_nettype wire
